FILE: sv/tdfs_pkg.sv
// Package for the table-driven feedback scheduler: payload structs, codes
// and default sizes. No dependencies.
`timescale 1ns / 1ps
package tdfs_pkg;

   localparam int LevelsDef     = 10;
   localparam int LevelDepthDef = 16;
   localparam int WaitDepthDef  = 16;
   localparam int TableSlotsDef = 32;

   localparam logic [0:0] OP_SUBMIT = 1'b0;
   localparam logic [0:0] OP_TICK   = 1'b1;

   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_REJECTED = 3'd1;
   localparam logic [2:0] ST_CONTINUE = 3'd2;
   localparam logic [2:0] ST_FINISHED = 3'd3;
   localparam logic [2:0] ST_IDLE     = 3'd4;
   localparam logic [2:0] ST_DROPPED  = 3'd5;

   localparam logic [1:0] CSR_QUANTUM    = 2'd0;
   localparam logic [1:0] CSR_SLOT_COUNT = 2'd1;
   localparam logic [1:0] CSR_TABLE_LOW  = 2'd2;
   localparam logic [1:0] CSR_TABLE_HIGH = 2'd3;

   typedef struct packed {
      logic [0:0]  operation;
      logic [15:0] job_id;
      logic [3:0]  start_level;
      logic [15:0] run_time;
      logic [15:0] arrival_tick;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] served_id;
      logic [3:0]  served_level;
      logic [15:0] time_left;
      logic [15:0] tick_number;
      logic [0:0]  all_empty;
   } rsp_type;

endpackage

FILE: sv/tdfs_core.sv
// Sequencer and storage of the feedback scheduler: waiting store, level FIFO
// memory and one shared compare/subtract step. Depends on tdfs_pkg.
`timescale 1ns / 1ps
module tdfs_core #(
   parameter int LEVELS      = tdfs_pkg::LevelsDef,
   parameter int LEVEL_DEPTH = tdfs_pkg::LevelDepthDef,
   parameter int WAIT_DEPTH  = tdfs_pkg::WaitDepthDef,
   parameter int TABLE_SLOTS = tdfs_pkg::TableSlotsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tdfs_pkg::req_type req,
   input  logic [15:0]       quantum,
   input  logic [5:0]        slot_count,
   input  logic [127:0]      slot_table,
   output logic              busy,
   output logic              rsp_valid,
   output tdfs_pkg::rsp_type rsp
);
   import tdfs_pkg::*;

   localparam int LW = $clog2(LEVELS);
   localparam int DW = $clog2(LEVEL_DEPTH);
   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam int WW = $clog2(WAIT_DEPTH);
   localparam int WC = $clog2(WAIT_DEPTH + 1);
   localparam int SW = $clog2(TABLE_SLOTS + 1);
   localparam int MW = $clog2(LEVELS * LEVEL_DEPTH);

   // Circular pointer step within one level FIFO.
   function automatic logic [DW-1:0] ptr_inc(logic [DW-1:0] p);
      return (32'(p) + 1 >= LEVEL_DEPTH) ? '0 : DW'(32'(p) + 1);
   endfunction

   typedef enum logic [2:0] {
      S_IDLE, S_MOVE_RD, S_MOVE, S_SEARCH, S_READ, S_SERVE, S_PUSH, S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  lvl;
      logic [15:0] run;
      logic [15:0] arr;
   } wait_type;

   state_type   state_ff, state_in;
   logic [31:0] lmem [LEVELS * LEVEL_DEPTH];
   logic [31:0] lrd_ff;
   wait_type    wmem [WAIT_DEPTH];
   wait_type    wrd_ff;
   logic [DW-1:0] head_ff [LEVELS];
   logic [DW-1:0] tail_ff [LEVELS];
   logic [CW-1:0] cnt_ff  [LEVELS];
   logic [WC-1:0] wcnt_ff;
   logic [WC-1:0] ri_ff, wj_ff;
   logic [15:0]   tick_ff;
   logic [SW-1:0] slot_ff;
   logic [LW-1:0] lv_ff;
   logic [LW:0]   k_ff;
   logic          busy_ff, valid_ff;
   rsp_type       rsp_ff;
   logic [15:0]   left_ff;

   // Shared arithmetic step: compare and subtract of remaining time.
   logic [15:0] q_eff;
   logic [16:0] diff;
   assign q_eff = (quantum == 16'd0) ? 16'd1 : quantum;
   assign diff  = {1'b0, lrd_ff[15:0]} - {1'b0, q_eff};

   logic [SW-1:0] cnt_eff, slot_use;
   logic [3:0]    want_raw;
   logic [LW-1:0] want;
   always_comb begin
      if (slot_count == 6'd0) cnt_eff = SW'(1);
      else if (32'(slot_count) > TABLE_SLOTS) cnt_eff = SW'(TABLE_SLOTS);
      else cnt_eff = SW'(slot_count);
      slot_use = (slot_ff >= cnt_eff) ? '0 : slot_ff;
      want_raw = slot_table[4 * slot_use[4:0] +: 4];
      if (want_raw == 4'd0 || 32'(want_raw) > LEVELS) want = '0;
      else want = LW'(want_raw - 4'd1);
   end

   wait_type   req_w;
   logic [3:0] lv_in;
   always_comb begin
      if (req.start_level == 4'd0) lv_in = 4'd1;
      else if (32'(req.start_level) > LEVELS) lv_in = 4'(LEVELS);
      else lv_in = req.start_level;
      req_w = '{id: req.job_id, lvl: lv_in, run: req.run_time, arr: req.arrival_tick};
   end

   // Result frame loaded when a command is taken.
   rsp_type start_rsp;
   always_comb begin
      start_rsp = '0;
      start_rsp.tick_number = tick_ff;
      if (req.operation == OP_SUBMIT) begin
         start_rsp.status = (32'(wcnt_ff) < WAIT_DEPTH) ? ST_ACCEPTED : ST_REJECTED;
      end else begin
         start_rsp.status = ST_IDLE;
      end
   end

   logic any_lvl;
   always_comb begin
      any_lvl = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
         if (cnt_ff[i] != '0) any_lvl = 1'b1;
      end
   end

   logic [LW-1:0] mlv, nl;
   assign mlv = LW'(wrd_ff.lvl - 4'd1);
   assign nl  = (32'(lv_ff) + 1 < LEVELS) ? LW'(lv_ff + 1'b1) : LW'(LEVELS - 1);

   logic [LW-1:0] lv_next;
   assign lv_next = (32'(lv_ff) + 1 >= LEVELS) ? '0 : LW'(lv_ff + 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (start && req.operation == OP_TICK) state_in = S_MOVE_RD;
                    else if (start) state_in = S_DONE;
         S_MOVE_RD: state_in = (ri_ff >= wcnt_ff) ? S_SEARCH : S_MOVE;
         S_MOVE:    state_in = S_MOVE_RD;
         S_SEARCH:  if (32'(k_ff) >= LEVELS) state_in = S_DONE;
                    else if (cnt_ff[lv_ff] != '0) state_in = S_READ;
         S_READ:    state_in = S_SERVE;
         S_SERVE:   state_in = S_PUSH;
         S_PUSH:    state_in = S_DONE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start && req.operation == OP_SUBMIT
          && 32'(wcnt_ff) < WAIT_DEPTH) begin
         wmem[wcnt_ff[WW-1:0]] <= req_w;
      end
      if (state_ff == S_MOVE_RD) wrd_ff <= wmem[ri_ff[WW-1:0]];
      if (state_ff == S_MOVE && !(wrd_ff.arr <= tick_ff &&
          32'(cnt_ff[mlv]) < LEVEL_DEPTH)) begin
         wmem[wj_ff[WW-1:0]] <= wrd_ff;
      end
      if (state_ff == S_MOVE && wrd_ff.arr <= tick_ff &&
          32'(cnt_ff[mlv]) < LEVEL_DEPTH) begin
         lmem[MW'(32'(mlv) * LEVEL_DEPTH + 32'(tail_ff[mlv]))] <=
            {wrd_ff.id, wrd_ff.run};
      end
      if (state_ff == S_READ) begin
         lrd_ff <= lmem[MW'(32'(lv_ff) * LEVEL_DEPTH + 32'(head_ff[lv_ff]))];
      end
      if (state_ff == S_PUSH && !diff[16] && diff[15:0] != 16'd0 &&
          32'(cnt_ff[nl]) < LEVEL_DEPTH) begin
         lmem[MW'(32'(nl) * LEVEL_DEPTH + 32'(tail_ff[nl]))] <=
            {lrd_ff[31:16], diff[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         wcnt_ff  <= '0;
         ri_ff    <= '0;
         wj_ff    <= '0;
         tick_ff  <= '0;
         slot_ff  <= '0;
         lv_ff    <= '0;
         k_ff     <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         rsp_ff   <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  busy_ff <= 1'b1;
                  ri_ff   <= '0;
                  wj_ff   <= '0;
                  rsp_ff  <= start_rsp;
                  if (req.operation == OP_SUBMIT && 32'(wcnt_ff) < WAIT_DEPTH) begin
                     wcnt_ff <= wcnt_ff + 1'b1;
                  end
               end
            end
            S_MOVE_RD: begin
               if (ri_ff >= wcnt_ff) begin
                  wcnt_ff <= wj_ff;
                  lv_ff   <= want;
                  k_ff    <= '0;
                  slot_ff <= (slot_use + 1'b1 >= cnt_eff) ? '0 : SW'(slot_use + 1'b1);
               end
            end
            S_MOVE: begin
               ri_ff <= ri_ff + 1'b1;
               if (wrd_ff.arr <= tick_ff && 32'(cnt_ff[mlv]) < LEVEL_DEPTH) begin
                  tail_ff[mlv] <= ptr_inc(tail_ff[mlv]);
                  cnt_ff[mlv]  <= cnt_ff[mlv] + 1'b1;
               end else begin
                  wj_ff <= wj_ff + 1'b1;
               end
            end
            S_SEARCH: begin
               if (32'(k_ff) < LEVELS && cnt_ff[lv_ff] == '0) begin
                  k_ff  <= k_ff + 1'b1;
                  lv_ff <= lv_next;
               end
            end
            S_READ: begin
               head_ff[lv_ff] <= ptr_inc(head_ff[lv_ff]);
               cnt_ff[lv_ff]  <= cnt_ff[lv_ff] - 1'b1;
               rsp_ff.served_level <= 4'(lv_ff) + 4'd1;
            end
            S_SERVE: begin
               rsp_ff.served_id <= lrd_ff[31:16];
               left_ff <= (!diff[16] && diff[15:0] != 16'd0) ? diff[15:0] : 16'd0;
            end
            S_PUSH: begin
               rsp_ff.time_left <= left_ff;
               if (left_ff == 16'd0) begin
                  rsp_ff.status <= ST_FINISHED;
               end else if (32'(cnt_ff[nl]) < LEVEL_DEPTH) begin
                  rsp_ff.status <= ST_CONTINUE;
                  tail_ff[nl]   <= ptr_inc(tail_ff[nl]);
                  cnt_ff[nl]    <= cnt_ff[nl] + 1'b1;
               end else begin
                  rsp_ff.status <= ST_DROPPED;
               end
            end
            S_DONE: begin
               busy_ff  <= 1'b0;
               valid_ff <= 1'b1;
               rsp_ff.all_empty <= (wcnt_ff == '0) && !any_lvl;
               if (rsp_ff.status != ST_ACCEPTED && rsp_ff.status != ST_REJECTED) begin
                  tick_ff <= tick_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;
endmodule

FILE: sv/table_driven_feedback_scheduler.sv
// Top level of the table-driven feedback scheduler: configuration registers
// and the scheduling core. Depends on tdfs_pkg and tdfs_core.
`timescale 1ns / 1ps
// Usage. A command transfer is taken when start is high and busy is low;
// req carries the operation (submit or tick) and the job fields. Exactly one
// result per command appears on rsp for one cycle with rsp_valid high; the
// receiver cannot stall it. A submit goes from the idle state straight to
// the done state, which drives its result. A tick walks the waiting store
// entry by entry, reading each entry and then moving it to its level FIFO
// if it has arrived and that FIFO has room, else keeping it waiting; it then
// searches the levels one per cycle, then reads, updates and requeues the
// served job through one shared compare/subtract step. A tick that finds
// no job in any level goes from the search straight to its result.
// busy stays high until the result is driven, and the next command can be
// taken at the edge that takes the result.
// The csr channel writes quantum, slot count and the two slot table words;
// it is always ready and should only be used while the block is idle.
// Synchronous reset empties all FIFOs and the waiting store, clears the
// tick counter and slot pointer and restores register defaults.
module table_driven_feedback_scheduler #(
   parameter int LEVELS      = tdfs_pkg::LevelsDef,
   parameter int LEVEL_DEPTH = tdfs_pkg::LevelDepthDef,
   parameter int WAIT_DEPTH  = tdfs_pkg::WaitDepthDef,
   parameter int TABLE_SLOTS = tdfs_pkg::TableSlotsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tdfs_pkg::req_type req_data,
   output logic              rsp_valid,
   output tdfs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata
);
   import tdfs_pkg::*;

   logic [15:0] quantum_ff;
   logic [5:0]  slot_count_ff;
   logic [63:0] table_low_ff, table_high_ff;

   assign csr_ready = 1'b1;

   // Register file; writes are applied on every completed transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff    <= 16'd1;
         slot_count_ff <= 6'd1;
         table_low_ff  <= 64'h1111111111111111;
         table_high_ff <= 64'h1111111111111111;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_QUANTUM:    quantum_ff    <= csr_wdata[15:0];
            CSR_SLOT_COUNT: slot_count_ff <= csr_wdata[5:0];
            CSR_TABLE_LOW:  table_low_ff  <= csr_wdata;
            CSR_TABLE_HIGH: table_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tdfs_core #(
      .LEVELS(LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH),
      .WAIT_DEPTH(WAIT_DEPTH), .TABLE_SLOTS(TABLE_SLOTS)
   ) u_core (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .quantum(quantum_ff), .slot_count(slot_count_ff),
      .slot_table({table_high_ff, table_low_ff}),
      .busy(busy), .rsp_valid(rsp_valid), .rsp(rsp_data)
   );
endmodule
